// ===== src/lsps_pkg.sv =====
package lsps_pkg;

  // Field and datapath widths
  localparam int BITS_W   = 6;   // sensor bits
  localparam int SPEED_W  = 8;   // base drive speed
  localparam int GAIN_W   = 16;  // Q8.8 gains
  localparam int LIM_W    = 8;   // speed limit
  localparam int CNT_W    = 3;   // active sensor count, 0..6
  localparam int WSUM_W   = 5;   // weighted sum, -9..9
  localparam int ERR_W    = 12;  // error, Q.8
  localparam int SUM_W    = 24;  // integral, Q.8
  localparam int DER_W    = 13;  // error difference
  localparam int OPB_W    = 25;  // multiplier signed operand
  localparam int PROD_W   = 42;  // product and accumulator
  localparam int FRAC_W   = 16;  // fraction bits of the accumulated total
  localparam int CORR_W   = PROD_W - FRAC_W;
  localparam int WHEEL_W  = CORR_W + 1;
  localparam int DRV_W    = 9;   // wheel drive output
  localparam int MODE_W   = 2;

  // Divider: dividend is |wsum| * 256
  localparam int DIV_W     = 12;
  localparam int DIV_STEPS = DIV_W;
  localparam int DSTEP_W   = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 3'd3;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd20480; // 80.0
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd0;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd11520; // 45.0
  localparam logic [LIM_W-1:0]  SPEED_LIM_RST  = 8'd255;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 24'sh7FFFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = 24'sh800000;

  localparam logic [CNT_W-1:0] ALL_ACTIVE = 3'd6;

  // Sensor i weight, bit 0 leftmost
  localparam logic signed [WSUM_W-1:0] SENSOR_WEIGHT [BITS_W] = '{
    5'sd5, 5'sd3, 5'sd1, -5'sd1, -5'sd3, -5'sd5
  };

  typedef enum logic [MODE_W-1:0] {
    MODE_PID      = 2'd0,
    MODE_SPIN     = 2'd1,
    MODE_STRAIGHT = 2'd2
  } steer_mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_PREP,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_DRAIN,
    S_CORR,
    S_FIN
  } seq_state_t;

  // Multiply-accumulate control
  typedef struct packed {
    logic issue;  // start a product this cycle
    logic clear;  // this product opens a new sum
  } mac_ctl_t;

endpackage

// ===== src/line_sensor_pid_steering_unit.sv =====
// Channel  Dir  Handshake              Payload (lowest bit up)
// in       in   in_tvalid/in_tready    tdata: line_bits[5:0], drive_speed[13:6]
// out      out  out_tvalid/out_tready  tdata: left_drive[8:0], right_drive[17:9];
//                                      tuser: steer_mode[1:0]
// cfg      in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// A tracking sample runs from accept to result through the bit-serial divide
// (12 quotient bits, then a check that it is done), the forming of error,
// integral and difference, the shared multiplier, and truncate and clamp.
// Line-lost and all-active samples skip the divide and multiplier. in_tready is
// high only in idle, so no new sample is taken until the last result is loaded;
// a held result stalls only the last step. Sync reset restores gains, limit, loop state.
module line_sensor_pid_steering_unit import lsps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input beats
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // line_bits[5:0], drive_speed[13:6]
  // result beats
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // left_drive[8:0], right_drive[17:9]
  output logic [MODE_W-1:0]     out_tuser,  // steer_mode[1:0]
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  seq_state_t state_r, state_nxt;

  // Configuration registers
  logic [GAIN_W-1:0] prop_gain_r, integ_gain_r, deriv_gain_r;
  logic [LIM_W-1:0]  speed_limit_r;

  // Controller state
  logic signed [ERR_W-1:0] prev_error_r;
  logic signed [SUM_W-1:0] error_sum_r;

  // Per-sample working registers
  logic [SPEED_W-1:0]       speed_r;
  steer_mode_t              mode_r;
  logic                     neg_r;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [DER_W-1:0]  deriv_r;
  logic signed [CORR_W-1:0] corr_r;

  // Output register
  logic                     out_valid_r;
  logic signed [DRV_W-1:0]  out_left_r, out_right_r;
  steer_mode_t              out_mode_r;

  // Beat decode
  logic [BITS_W-1:0]        in_bits;
  logic [SPEED_W-1:0]       in_speed;
  logic signed [WSUM_W-1:0] wsum;
  logic [CNT_W-1:0]         count;
  logic [WSUM_W-2:0]        wmag;
  steer_mode_t              in_mode;
  logic                     in_acc;

  // Sequencer outputs
  logic     div_start;
  logic     div_busy;
  logic     fin_load;
  logic     out_free;
  mac_ctl_t mac_ctl;

  logic [DIV_W-1:0]          quotient;
  logic signed [PROD_W-1:0]  acc;
  logic [GAIN_W-1:0]         mac_gain;
  logic signed [OPB_W-1:0]   mac_opb;

  // Error prep
  logic signed [ERR_W-1:0]   err_nxt;
  logic signed [SUM_W:0]     sum_wide;
  logic signed [SUM_W-1:0]   sum_nxt;
  logic signed [DER_W-1:0]   deriv_nxt;

  // Truncate and clamp
  logic signed [PROD_W-1:0]  acc_biased;
  logic signed [WHEEL_W-1:0] speed_w, corr_w, lim_w;
  logic signed [WHEEL_W-1:0] left_w, right_w;
  logic signed [DRV_W-1:0]   left_pid, right_pid;
  logic signed [DRV_W-1:0]   spd9, nspd9;
  logic signed [DRV_W-1:0]   left_out, right_out;

  // ---------------------------------------------------------------
  // Input decode: weighted sum and active count over six sensors
  // ---------------------------------------------------------------
  assign in_bits  = in_tdata[BITS_W-1:0];
  assign in_speed = in_tdata[BITS_W+SPEED_W-1:BITS_W];

  always_comb begin
    wsum  = '0;
    count = '0;
    for (int i = 0; i < BITS_W; i++) begin
      if (in_bits[i]) begin
        wsum  = wsum + SENSOR_WEIGHT[i];
        count = count + 1'b1;
      end
    end
    wmag = wsum[WSUM_W-1] ? (WSUM_W-1)'(-wsum) : wsum[WSUM_W-2:0];
    if (count == '0) begin
      in_mode = MODE_SPIN;
    end else if (count == ALL_ACTIVE) begin
      in_mode = MODE_STRAIGHT;
    end else begin
      in_mode = MODE_PID;
    end
  end

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // ---------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = (in_mode == MODE_PID) ? S_DIV : S_FIN;
      S_DIV:   if (!div_busy) state_nxt = S_PREP;
      S_PREP:  state_nxt = S_MUL_P;
      S_MUL_P: state_nxt = S_MUL_I;
      S_MUL_I: state_nxt = S_MUL_D;
      S_MUL_D: state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_CORR;
      S_CORR:  state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    fin_load      = 1'b0;
    mac_ctl       = '0;
    mac_gain      = prop_gain_r;
    mac_opb       = OPB_W'(err_r);
    unique case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_MUL_P: begin
        mac_ctl  = '{issue: 1'b1, clear: 1'b1};
        mac_gain = prop_gain_r;
        mac_opb  = OPB_W'(err_r);
      end
      S_MUL_I: begin
        mac_ctl  = '{issue: 1'b1, clear: 1'b0};
        mac_gain = integ_gain_r;
        mac_opb  = OPB_W'(sum_r);
      end
      S_MUL_D: begin
        mac_ctl  = '{issue: 1'b1, clear: 1'b0};
        mac_gain = deriv_gain_r;
        mac_opb  = OPB_W'(deriv_r);
      end
      S_FIN: fin_load = out_free;
      default: ;
    endcase
  end

  assign div_start = in_acc && (in_mode == MODE_PID);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Shared units
  // ---------------------------------------------------------------
  lsps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({wmag, 8'd0}),
    .divisor  (count),
    .busy     (div_busy),
    .quotient (quotient)
  );

  lsps_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mac_ctl),
    .gain    (mac_gain),
    .operand (mac_opb),
    .acc     (acc)
  );

  // ---------------------------------------------------------------
  // Error, saturated integral, difference
  // ---------------------------------------------------------------
  always_comb begin
    err_nxt  = neg_r ? -$signed(quotient) : $signed(quotient);
    sum_wide = $signed({error_sum_r[SUM_W-1], error_sum_r}) + (SUM_W+1)'(err_nxt);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_nxt = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_nxt = sum_wide[SUM_W-1:0];
    end
    deriv_nxt = DER_W'(err_nxt) - DER_W'(prev_error_r);
  end

  // ---------------------------------------------------------------
  // Truncation toward zero, wheel mix and clamp
  // ---------------------------------------------------------------
  always_comb begin
    acc_biased = acc + (acc[PROD_W-1] ? PROD_W'((1 << FRAC_W) - 1) : PROD_W'(0));
    speed_w    = $signed(WHEEL_W'({1'b0, speed_r}));
    corr_w     = WHEEL_W'(corr_r);
    lim_w      = $signed(WHEEL_W'({1'b0, speed_limit_r}));
    left_w     = speed_w + corr_w;
    right_w    = speed_w - corr_w;

    if (left_w > lim_w)       left_pid = DRV_W'(lim_w);
    else if (left_w < -lim_w) left_pid = DRV_W'(-lim_w);
    else                      left_pid = DRV_W'(left_w);

    if (right_w > lim_w)       right_pid = DRV_W'(lim_w);
    else if (right_w < -lim_w) right_pid = DRV_W'(-lim_w);
    else                       right_pid = DRV_W'(right_w);

    spd9  = $signed({1'b0, speed_r});
    nspd9 = -spd9;

    unique case (mode_r)
      MODE_SPIN: begin
        // spin toward the side of the last error
        left_out  = (prev_error_r > 0) ? spd9 : nspd9;
        right_out = (prev_error_r > 0) ? nspd9 : spd9;
      end
      MODE_STRAIGHT: begin
        left_out  = spd9;
        right_out = spd9;
      end
      default: begin
        left_out  = left_pid;
        right_out = right_pid;
      end
    endcase
  end

  // ---------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      speed_r <= in_speed;
      mode_r  <= in_mode;
      neg_r   <= wsum[WSUM_W-1];
    end
    if (state_r == S_PREP) begin
      err_r   <= err_nxt;
      sum_r   <= sum_nxt;
      deriv_r <= deriv_nxt;
    end
    if (state_r == S_CORR) begin
      corr_r <= acc_biased[PROD_W-1:FRAC_W];
    end
    if (fin_load) begin
      out_left_r  <= left_out;
      out_right_r <= right_out;
      out_mode_r  <= mode_r;
    end
  end

  // Controller state commits only on a tracking result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_error_r <= '0;
      error_sum_r  <= '0;
    end else if (fin_load && (mode_r == MODE_PID)) begin
      prev_error_r <= err_r;
      error_sum_r  <= sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------
  // Register writes; unknown indexes are dropped
  // ---------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r   <= PROP_GAIN_RST;
      integ_gain_r  <= INTEG_GAIN_RST;
      deriv_gain_r  <= DERIV_GAIN_RST;
      speed_limit_r <= SPEED_LIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PROP_GAIN:   prop_gain_r   <= cfg_data;
        REG_INTEG_GAIN:  integ_gain_r  <= cfg_data;
        REG_DERIV_GAIN:  deriv_gain_r  <= cfg_data;
        REG_SPEED_LIMIT: speed_limit_r <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_right_r, out_left_r};
  assign out_tuser  = out_mode_r;

endmodule

// ===== src/lsps_div.sv =====
module lsps_div import lsps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_W-1:0]   dividend,
  input  logic [CNT_W-1:0]   divisor,
  output logic               busy,
  output logic [DIV_W-1:0]   quotient
);

  // Restoring division, one quotient bit per cycle.
  logic               busy_r;
  logic [DSTEP_W-1:0] cnt_r;
  logic [CNT_W-1:0]   rem_r;
  logic [DIV_W-1:0]   quo_r;
  logic [CNT_W-1:0]   dvs_r;

  logic [CNT_W:0]     trial;
  logic               ge;
  logic [CNT_W-1:0]   rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[DIV_W-1]};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? CNT_W'(trial - {1'b0, dvs_r}) : trial[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      rem_r  <= '0;
      quo_r  <= dividend;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_W-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DSTEP_W'(DIV_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// ===== src/lsps_mac.sv =====
module lsps_mac import lsps_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctl_t                 ctl,
  input  logic        [GAIN_W-1:0] gain,
  input  logic signed [OPB_W-1:0]  operand,
  output logic signed [PROD_W-1:0] acc
);

  // Shared multiplier; the product is registered and accumulated in the following cycle.
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] acc_r;
  logic                     pvld_r;
  logic                     pclr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
      pclr_r <= 1'b0;
    end else begin
      pvld_r <= ctl.issue;
      pclr_r <= ctl.clear;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      prod_r <= $signed({1'b0, gain}) * operand;
    end
    if (pvld_r) begin
      acc_r <= pclr_r ? prod_r : acc_r + prod_r;
    end
  end

  assign acc = acc_r;

endmodule

// ===== tb/line_sensor_pid_steering_unit_tb.sv =====
module line_sensor_pid_steering_unit_tb import lsps_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Watchdog limit: cycles in a row with no beat on any channel. The longest
  // legal quiet stretch is the receiver hold-off plus one sample's latency.
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int HOLD_AFTER   = 60;    // results seen before the hold-off starts
  localparam int SETTLE       = 25;    // quiet cycles before a register write
  localparam int MAX_WAIT     = 16;    // per-beat gap / stall upper bound

  // Indexes past the last register; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_SPEED_LIMIT + 3'd1;

  typedef struct {
    logic [BITS_W-1:0]  bits;
    logic [SPEED_W-1:0] speed;
  } line_sample_t;

  typedef struct {
    logic [DRV_W-1:0] left;
    logic [DRV_W-1:0] right;
    steer_mode_t      mode;
  } drive_beat_t;

  // Sensor weights, bit 0 first
  localparam int SENSOR_WT [BITS_W] = '{5, 3, 1, -1, -3, -5};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;
  logic [MODE_W-1:0]     out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  line_sensor_pid_steering_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block's registers and loop state
  logic [GAIN_W-1:0]        kp_gain     = PROP_GAIN_RST;
  logic [GAIN_W-1:0]        ki_gain     = INTEG_GAIN_RST;
  logic [GAIN_W-1:0]        kd_gain     = DERIV_GAIN_RST;
  logic [LIM_W-1:0]         wheel_limit = SPEED_LIM_RST;
  logic signed [ERR_W-1:0]  est_prev_error = '0;
  logic signed [SUM_W-1:0]  est_error_sum  = '0;

  line_sample_t sample_queue[$];     // samples waiting for the driver
  drive_beat_t  drive_expected[$];   // predicted wheel drives, oldest first

  // Handshake flags sampled at the rising edge, used by the falling-edge drivers
  logic in_took  = 1'b0;
  logic out_took = 1'b0;

  bit          no_idle = 1'b0;      // back-to-back stretches, no gaps or stalls
  int          results_seen = 0;
  int          fail_count = 0;
  int          in_gap = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          idle_cycles = 0;
  line_sample_t drv_sample;

  function automatic longint clamp_wheel(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Predict one sample's wheel drives and advance the shadow loop state.
  function automatic void steer_predict(input logic [BITS_W-1:0] bits,
                                        input logic [SPEED_W-1:0] speed);
    int          wsum;
    int          cnt;
    int          err;
    longint      spd;
    longint      sum_next;
    longint      deriv;
    longint      total;
    longint      corr;
    longint      lim;
    longint      lft;
    longint      rgt;
    drive_beat_t beat;
    wsum = 0;
    cnt  = 0;
    spd  = longint'(speed);
    lim  = longint'(wheel_limit);
    for (int i = 0; i < BITS_W; i++) begin
      if (bits[i]) begin
        wsum += SENSOR_WT[i];
        cnt++;
      end
    end
    if (cnt == 0) begin
      // line lost: spin toward the side of the last error, no clamp
      if (est_prev_error > 0) begin
        lft = spd;
        rgt = -spd;
      end else begin
        lft = -spd;
        rgt = spd;
      end
      beat.mode = MODE_SPIN;
    end else if (cnt == BITS_W) begin
      // every sensor on the line: straight ahead, no clamp
      lft = spd;
      rgt = spd;
      beat.mode = MODE_STRAIGHT;
    end else begin
      err = (wsum * 256) / cnt;                 // truncates toward zero
      sum_next = longint'(est_error_sum) + err;
      if (sum_next > longint'(SUM_MAX)) sum_next = longint'(SUM_MAX);
      if (sum_next < longint'(SUM_MIN)) sum_next = longint'(SUM_MIN);
      deriv = longint'(err) - longint'(est_prev_error);
      total = longint'(kp_gain) * err + longint'(ki_gain) * sum_next
            + longint'(kd_gain) * deriv;
      corr  = total / 65536;                    // Q.16 -> integer, toward zero
      lft   = clamp_wheel(spd + corr, lim);
      rgt   = clamp_wheel(spd - corr, lim);
      est_error_sum  = sum_next[SUM_W-1:0];
      est_prev_error = err[ERR_W-1:0];
      beat.mode = MODE_PID;
    end
    beat.left  = lft[DRV_W-1:0];
    beat.right = rgt[DRV_W-1:0];
    drive_expected.push_back(beat);
  endfunction

  // Rising edge: note handshakes, predict on input beats, check result beats.
  always @(posedge clk) begin
    drive_beat_t want;
    in_took  <= in_tvalid && in_tready;
    out_took <= out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready) begin
      steer_predict(in_tdata[BITS_W-1:0], in_tdata[BITS_W +: SPEED_W]);
    end
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (drive_expected.size() == 0) begin
        $display("%0t result beat with nothing expected: left %0d right %0d mode %0d",
                 $time, $signed(out_tdata[8:0]), $signed(out_tdata[17:9]), out_tuser);
        fail_count++;
      end else begin
        want = drive_expected.pop_front();
        if (out_tdata[8:0] !== want.left) begin
          $display("%0t left_drive expected %0d got %0d", $time,
                   $signed(want.left), $signed(out_tdata[8:0]));
          fail_count++;
        end
        if (out_tdata[17:9] !== want.right) begin
          $display("%0t right_drive expected %0d got %0d", $time,
                   $signed(want.right), $signed(out_tdata[17:9]));
          fail_count++;
        end
        if (out_tuser !== want.mode) begin
          $display("%0t steer_mode expected %0d got %0d", $time, want.mode, out_tuser);
          fail_count++;
        end
      end
    end
  end

  // Sender: falling edge. A beat is held until taken; after each taken beat a
  // gap of 0..MAX_WAIT cycles is drawn. A zero gap keeps tvalid high with the
  // next sample, so tvalid never drops and rises within one step.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_gap = 0;
    end else if (!in_tvalid || in_took) begin
      if (in_took) in_gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (sample_queue.size() > 0) begin
        drv_sample = sample_queue.pop_front();
        in_tdata  <= {2'b00, drv_sample.speed, drv_sample.bits};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: falling edge. Random stall after each result beat, plus one long
  // hold-off once enough results have come, so the block backs up and drops
  // in_tready while the sender keeps offering.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_took) stall_left = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: a run of quiet cycles on every channel means the block hung.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t timeout: no beat for %0d cycles", $time, idle_cycles);
      $display("** line_sensor_pid_steering_unit: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Register write; updates the shadow copy once the beat is taken.
  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PROP_GAIN:   kp_gain     = val;
      REG_INTEG_GAIN:  ki_gain     = val;
      REG_DERIV_GAIN:  kd_gain     = val;
      REG_SPEED_LIMIT: wheel_limit = val[LIM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_sample(input logic [BITS_W-1:0] bits,
                             input logic [SPEED_W-1:0] speed);
    line_sample_t s;
    s.bits  = bits;
    s.speed = speed;
    sample_queue.push_back(s);
  endtask

  // Mostly partial line patterns; line lost and all-on now and then, speed
  // extremes now and then.
  task automatic push_random(input int n);
    line_sample_t s;
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) s.bits = '0;
      else if (pick == 1) s.bits = '1;
      else s.bits = BITS_W'($urandom_range(1, 62));
      pick = $urandom_range(0, 9);
      if (pick == 0) s.speed = '0;
      else if (pick == 1) s.speed = '1;
      else s.speed = SPEED_W'($urandom_range(0, 255));
      sample_queue.push_back(s);
    end
  endtask

  // Wait for every queued sample to go in and every result to come out, then
  // let the block settle before touching registers.
  task automatic drain_and_settle();
    while (sample_queue.size() != 0 || in_tvalid || drive_expected.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_all(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                           input logic [GAIN_W-1:0] kd, input logic [LIM_W-1:0] lim);
    reg_write(REG_PROP_GAIN, kp);
    reg_write(REG_INTEG_GAIN, ki);
    reg_write(REG_DERIV_GAIN, kd);
    reg_write(REG_SPEED_LIMIT, {8'h00, lim});
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, reset gains (Kp 80, Ki 0, Kd 45, limit 255)
    push_sample(6'b000000, 8'd0);     // line lost, last error zero
    push_sample(6'b000000, 8'd255);   // line lost, spins left-back
    push_sample(6'b111111, 8'd255);   // all on, straight
    push_sample(6'b111111, 8'd0);
    push_sample(6'b000001, 8'd255);   // max positive error, both wheels clamp
    push_sample(6'b000000, 8'd200);   // lost after positive error
    push_sample(6'b100000, 8'd0);     // max negative error
    push_sample(6'b000000, 8'd100);   // lost after negative error
    push_sample(6'b000010, 8'd128);
    push_sample(6'b000100, 8'd128);
    push_sample(6'b001000, 8'd128);
    push_sample(6'b010000, 8'd128);
    push_sample(6'b000011, 8'd50);
    push_sample(6'b000111, 8'd90);
    push_sample(6'b001011, 8'd77);    // 7/3, positive truncation
    push_sample(6'b110100, 8'd77);    // -7/3, truncation toward zero
    push_sample(6'b011111, 8'd128);
    push_sample(6'b111110, 8'd128);
    push_sample(6'b001100, 8'd10);    // balanced pair, zero error
    push_sample(6'b100001, 8'd255);   // outer pair, zero error
    push_sample(6'b111111, 8'd17);
    push_sample(6'b000000, 8'd1);     // lost with last error zero
    push_sample(6'b010101, 8'd255);
    push_sample(6'b101010, 8'd0);
    // Random at reset gains; the long receiver hold-off lands here
    push_random(150);
    drain_and_settle();

    // Random gains, plus writes to the unused indexes that must change nothing
    write_all(GAIN_W'($urandom_range(0, 65535)), GAIN_W'($urandom_range(0, 255)),
              GAIN_W'($urandom_range(0, 65535)), LIM_W'($urandom_range(0, 255)));
    for (int i = 0; i < 4; i++) begin
      reg_write(CFG_IDX_W'(REG_FIRST_UNUSED + i), CFG_DATA_W'($urandom_range(0, 65535)));
    end
    push_random(130);
    drain_and_settle();

    // Every register at its top
    write_all('1, '1, '1, '1);
    push_random(100);
    drain_and_settle();

    // Every register at zero: PID wheels pinned to zero, spin and straight not
    write_all('0, '0, '0, '0);
    push_random(100);
    drain_and_settle();

    // Moderate gains, small limit
    write_all(GAIN_W'($urandom_range(0, 8191)), GAIN_W'($urandom_range(0, 63)),
              GAIN_W'($urandom_range(0, 8191)), LIM_W'($urandom_range(1, 64)));
    push_random(100);
    drain_and_settle();

    // Unity Kp, heavy Kd, mid limit
    write_all(16'h0100, GAIN_W'($urandom_range(0, 15)), '1, 8'd128);
    push_random(100);
    drain_and_settle();

    // Integral term only, Ki = 1.0, so the correction is the integral in
    // whole units and ramps up, then back down, in the left wheel.
    write_all('0, 16'h0100, '0, 8'd255);
    no_idle = 1'b1;
    repeat (15) push_sample(6'b000001, 8'd100);
    drain_and_settle();
    repeat (15) push_sample(6'b100000, 8'd100);
    drain_and_settle();
    no_idle = 1'b0;

    if (fail_count == 0) begin
      $display("** line_sensor_pid_steering_unit: PASSED **");
    end else begin
      $display("** line_sensor_pid_steering_unit: FAILED **");
    end
    $finish;
  end

endmodule
